>>> src/aes_block_encrypt_unit_defines.svh
// Assertion macros used by the checker file
`ifndef AES_BLOCK_ENCRYPT_UNIT_DEFINES_SVH
`define AES_BLOCK_ENCRYPT_UNIT_DEFINES_SVH

`define ABE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ABE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/aes_pkg.sv
package aes_pkg;

    localparam int unsigned BLK_W   = 128;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned NR_W    = 4;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned MIN_NR  = 10;

    typedef enum logic [0:0] {
        OP_LOAD    = 1'b0,
        OP_ENCRYPT = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [0:0]        opcode;
        logic [SLOT_W-1:0] key_slot;
        logic [WORD_W-1:0] word_high;
        logic [WORD_W-1:0] word_low;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] cipher_high;
        logic [WORD_W-1:0] cipher_low;
    } t_out_item;

    typedef struct packed {
        logic en;
        logic start;
        logic last;
    } t_rnd_ctrl;

    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[x];
    endfunction

endpackage

>>> src/aes_round.sv
module aes_round
    import aes_pkg::*;
(
    input  logic             i_clk,
    input  t_rnd_ctrl        i_ctrl,
    input  logic [BLK_W-1:0] i_init,
    input  logic [BLK_W-1:0] i_key,
    output logic [BLK_W-1:0] o_state
);

    logic [BLK_W-1:0] r_state;
    logic [BLK_W-1:0] n_state;
    logic [7:0]       s   [16];
    logic [7:0]       t   [16];
    logic [7:0]       m   [16];

    always_comb begin
        logic [7:0] a0, a1, a2, a3, all;
        for (int i = 0; i < 16; i++) begin
            s[i] = r_state[BLK_W-1-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            m[4*c]   = i_ctrl.last ? a0 : a0 ^ all ^ gf_xtime(a0 ^ a1);
            m[4*c+1] = i_ctrl.last ? a1 : a1 ^ all ^ gf_xtime(a1 ^ a2);
            m[4*c+2] = i_ctrl.last ? a2 : a2 ^ all ^ gf_xtime(a2 ^ a3);
            m[4*c+3] = i_ctrl.last ? a3 : a3 ^ all ^ gf_xtime(a3 ^ a0);
        end
        for (int i = 0; i < 16; i++) begin
            n_state[BLK_W-1-8*i -: 8] = m[i];
        end
        n_state = (i_ctrl.start ? i_init : n_state) ^ i_key;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

>>> src/aes_block_encrypt_unit.sv
// channel  | dir | handshake               | payload
// in       | in  | i_in_valid/o_in_ready   | i_in_data  (t_in_item)
// out      | out | o_out_valid/i_out_ready | o_out_data (t_out_item)
// cfg      | in  | psel/penable/pready     | round_count at address 0
// A load writes one key slot if it is at most MAX_ROUNDS; loads run back to back.
// An encrypt passes through the round unit (key addition, then one round per
// cycle), the item is valid on the next cycle, and input is ready
// again in the cycle after it is taken.
// Reset clears control and round_count to 10; key slots are undefined until loaded.
// A stalled output holds the block and blocks new items.
module aes_block_encrypt_unit
    import aes_pkg::*;
#(
    parameter int unsigned MAX_ROUNDS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned SLOTS = MAX_ROUNDS + 1;

    logic [BLK_W-1:0] r_keys [SLOTS];
    logic [BLK_W-1:0] r_key_q;
    logic [NR_W-1:0]  r_nr_cfg;
    logic [NR_W-1:0]  r_rnd, n_rnd;
    logic [NR_W-1:0]  r_nr, n_nr;
    logic [NR_W-1:0]  rd_slot;
    logic [NR_W-1:0]  nr_eff;
    t_state           r_state, n_state;
    t_rnd_ctrl        ctrl;
    logic [BLK_W-1:0] r_blk;
    logic             r_first, n_first;
    logic             in_acc;
    logic [BLK_W-1:0] st;

    assign pready = 1'b1;
    assign prdata = {{(32-NR_W){1'b0}}, r_nr_cfg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nr_cfg <= NR_W'(MIN_NR);
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_nr_cfg <= pwdata[NR_W-1:0];
        end
    end

    always_comb begin
        if (r_nr_cfg < NR_W'(MIN_NR)) nr_eff = NR_W'(MIN_NR);
        else if (r_nr_cfg > NR_W'(MAX_ROUNDS)) nr_eff = NR_W'(MAX_ROUNDS);
        else nr_eff = r_nr_cfg;
    end

    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc && i_in_data.opcode == OP_ENCRYPT) n_state = ST_ROUND;
            ST_ROUND: if (!r_first && r_rnd == r_nr) n_state = ST_OUT;
            ST_OUT: if (i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_rnd = r_rnd;
        n_nr = r_nr;
        n_first = r_first;
        rd_slot = '0;
        if (r_state == ST_IDLE) begin
            n_rnd = '0;
            n_nr = nr_eff;
            n_first = 1'b1;
            rd_slot = '0;
        end else if (r_state == ST_ROUND) begin
            n_first = 1'b0;
            n_rnd = r_rnd + NR_W'(1);
            rd_slot = (r_rnd == r_nr) ? r_rnd : r_rnd + NR_W'(1);
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd <= '0;
            r_nr <= NR_W'(MIN_NR);
            r_first <= 1'b1;
        end else begin
            r_state <= n_state;
            r_rnd <= n_rnd;
            r_nr <= n_nr;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.opcode == OP_LOAD && i_in_data.key_slot < NR_W'(SLOTS)) begin
            r_keys[i_in_data.key_slot] <= {i_in_data.word_high, i_in_data.word_low};
        end
        r_key_q <= r_keys[rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_blk <= {i_in_data.word_high, i_in_data.word_low};
        end
    end

    assign ctrl.en = (r_state == ST_ROUND);
    assign ctrl.start = r_first;
    assign ctrl.last = (r_rnd == r_nr);

    aes_round u_round (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_init  (r_blk),
        .i_key   (r_key_q),
        .o_state (st)
    );

    assign o_out_data.cipher_high = st[BLK_W-1 -: WORD_W];
    assign o_out_data.cipher_low = st[WORD_W-1:0];

endmodule

>>> src/aes_block_encrypt_unit_checker.sv
`include "aes_block_encrypt_unit_defines.svh"
module aes_block_encrypt_unit_checker
    import aes_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_data,
    input logic        pready
);
    logic out_stall;
    logic in_wait;

    assign out_stall = o_out_valid && !i_out_ready;
    assign in_wait = i_in_valid && !o_in_ready;

    `ABE_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `ABE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_data))
    `ABE_ASSERT_NEXT(a_drop, i_clk, i_rst_n, o_out_valid && i_out_ready, !o_out_valid)
    `ABE_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_wait, i_in_valid)
    `ABE_ASSERT_IMP(a_pready, i_clk, i_rst_n, 1'b1, pready)
endmodule

bind aes_block_encrypt_unit aes_block_encrypt_unit_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
    .pready(pready)
);
